// ----- design/pps_pkg.sv -----
// Package for the particle pool core: widths, reset values, codes, the pool
// entry type, and the command and status types shared by the controller and
// datapath. No dependencies.
`default_nettype none
package pps_pkg;

   localparam int POOL_SIZE_DEF = 64;
   localparam int SLOT_W        = 6;
   localparam int WORD_W        = 32;
   localparam int COUNT_W       = 7;
   localparam int SCALE_W       = 31;
   localparam int SEED_W        = 16;
   localparam int ALPHA_W       = 17;
   localparam int CSR_IDX_W     = 4;

   localparam logic [COUNT_W-1:0] RESET_SPAWN_COUNT = 7'd30;
   localparam logic [WORD_W-1:0]  RESET_INIT_LIFE   = 32'd65536;
   localparam logic [SCALE_W-1:0] RESET_VEL_SCALE   = 31'd327680;
   localparam logic [SEED_W-1:0]  RESET_SEED        = 16'd44257;
   localparam logic [SEED_W-1:0]  LFSR_TAPS         = 16'hB400;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE         = 17'd65536;

   localparam logic [CSR_IDX_W-1:0] REG_SPAWN_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_LIFE   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_SCALE   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEED        = 4'd3;

   localparam logic OP_SPAWN = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Multiplier operand selection.
   localparam logic [2:0] MUL_CENTER = 3'd0;
   localparam logic [2:0] MUL_UP     = 3'd1;
   localparam logic [2:0] MUL_TX     = 3'd2;
   localparam logic [2:0] MUL_TY     = 3'd3;
   localparam logic [2:0] MUL_TZ     = 3'd4;

   // Result register source.
   localparam logic [1:0] OUT_SPAWN     = 2'd0;
   localparam logic [1:0] OUT_HOLD_MID  = 2'd1;
   localparam logic [1:0] OUT_HOLD_LAST = 2'd2;
   localparam logic [1:0] OUT_EMPTY     = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] life;
      logic [WORD_W-1:0] pos_x;
      logic [WORD_W-1:0] pos_y;
      logic [WORD_W-1:0] pos_z;
      logic [WORD_W-1:0] vel_x;
      logic [WORD_W-1:0] vel_y;
      logic [WORD_W-1:0] vel_z;
   } pps_entry_type;

   localparam int ENTRY_W = $bits(pps_entry_type);

   typedef struct packed {
      logic              load_req;
      logic [2:0]        mul_sel;
      logic              lfsr_step;
      logic              vel_x_load;
      logic              vel_y_load;
      logic              spawn_write;
      logic              rd_en;
      logic              kill;
      logic              life_load;
      logic              pos_x_load;
      logic              pos_y_load;
      logic              tick_write;
      logic              hold_load;
      logic              out_load;
      logic [1:0]        out_sel;
      logic [SLOT_W-1:0] slot;
   } pps_cmd_type;

   typedef struct packed {
      logic alive_bit;
      logic spawn_full;
      logic dead;
      logic div_done;
      logic out_busy;
      logic hold_valid;
   } pps_status_type;

endpackage
`default_nettype wire

// ----- design/pps_if.sv -----
// Valid/ready channel interfaces for the particle pool core.
// Depends on pps_pkg for the field widths.
`default_nettype none
interface pps_req_if import pps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic signed [WORD_W-1:0] spawn_x;
   logic signed [WORD_W-1:0] spawn_y;
   logic signed [WORD_W-1:0] spawn_z;
   logic [WORD_W-1:0]        elapsed_time;
   modport source (output valid, opcode, spawn_x, spawn_y, spawn_z, elapsed_time,
                   input ready);
   modport sink (input valid, opcode, spawn_x, spawn_y, spawn_z, elapsed_time,
                 output ready);
endinterface

interface pps_rsp_if import pps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [SLOT_W-1:0]        slot;
   logic signed [WORD_W-1:0] pos_x;
   logic signed [WORD_W-1:0] pos_y;
   logic signed [WORD_W-1:0] pos_z;
   logic [ALPHA_W-1:0]       alpha;
   logic                     alive;
   logic [COUNT_W-1:0]       spawned;
   logic                     last;
   modport source (output valid, kind, slot, pos_x, pos_y, pos_z, alpha, alive,
                   spawned, last, input ready);
   modport sink (input valid, kind, slot, pos_x, pos_y, pos_z, alpha, alive,
                 spawned, last, output ready);
endinterface
`default_nettype wire

// ----- design/pps_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module pps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- design/pps_ctrl.sv -----
// Controller for the particle pool core: walks the slots for spawn and tick
// items and sequences the datapath. Depends on pps_pkg.
`default_nettype none
module pps_ctrl import pps_pkg::*; #(
   parameter int POOL_SIZE = POOL_SIZE_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_opcode,
   output logic                req_ready,
   output pps_cmd_type         cmd,
   input  wire pps_status_type status
);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SIZE - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCAN   = 4'd1;
   localparam logic [3:0] ST_VX     = 4'd2;
   localparam logic [3:0] ST_VY     = 4'd3;
   localparam logic [3:0] ST_VZ     = 4'd4;
   localparam logic [3:0] ST_SWR    = 4'd5;
   localparam logic [3:0] ST_REPORT = 4'd6;
   localparam logic [3:0] ST_TRD    = 4'd7;
   localparam logic [3:0] ST_TCHK   = 4'd8;
   localparam logic [3:0] ST_TMY    = 4'd9;
   localparam logic [3:0] ST_TMZ    = 4'd10;
   localparam logic [3:0] ST_TWB    = 4'd11;
   localparam logic [3:0] ST_TDIV   = 4'd12;
   localparam logic [3:0] ST_TEMIT  = 4'd13;
   localparam logic [3:0] ST_TEND   = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              at_last;

   assign at_last   = (slot_ff == LAST_SLOT);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      cmd      = '0;
      cmd.slot = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               slot_in      = '0;
               state_in     = (req_opcode == OP_TICK) ? ST_TRD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.spawn_full) begin
               state_in = ST_REPORT;
            end else if (!status.alive_bit) begin
               state_in = ST_VX;
            end else if (at_last) begin
               state_in = ST_REPORT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_VX: begin
            cmd.lfsr_step = 1'b1;
            cmd.mul_sel   = MUL_CENTER;
            state_in      = ST_VY;
         end
         ST_VY: begin
            cmd.vel_x_load = 1'b1;
            cmd.lfsr_step  = 1'b1;
            cmd.mul_sel    = MUL_UP;
            state_in       = ST_VZ;
         end
         ST_VZ: begin
            cmd.vel_y_load = 1'b1;
            cmd.lfsr_step  = 1'b1;
            cmd.mul_sel    = MUL_CENTER;
            state_in       = ST_SWR;
         end
         ST_SWR: begin
            cmd.spawn_write = 1'b1;
            if (at_last) begin
               state_in = ST_REPORT;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_REPORT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_SPAWN;
               state_in     = ST_IDLE;
            end
         end
         ST_TRD: begin
            if (status.alive_bit) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_TCHK;
            end else if (at_last) begin
               state_in = ST_TEND;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_TCHK: begin
            if (status.dead) begin
               cmd.kill = 1'b1;
               if (at_last) begin
                  state_in = ST_TEND;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_TRD;
               end
            end else begin
               cmd.life_load = 1'b1;
               cmd.mul_sel   = MUL_TX;
               state_in      = ST_TMY;
            end
         end
         ST_TMY: begin
            cmd.pos_x_load = 1'b1;
            cmd.mul_sel    = MUL_TY;
            state_in       = ST_TMZ;
         end
         ST_TMZ: begin
            cmd.pos_y_load = 1'b1;
            cmd.mul_sel    = MUL_TZ;
            state_in       = ST_TWB;
         end
         ST_TWB: begin
            cmd.tick_write = 1'b1;
            state_in       = ST_TDIV;
         end
         ST_TDIV: begin
            if (status.div_done) begin
               state_in = ST_TEMIT;
            end
         end
         ST_TEMIT: begin
            // The previous survivor goes out only once this one exists, so
            // that the final one can carry the last flag.
            if (!status.hold_valid || !status.out_busy) begin
               cmd.out_load  = status.hold_valid;
               cmd.out_sel   = OUT_HOLD_MID;
               cmd.hold_load = 1'b1;
               if (at_last) begin
                  state_in = ST_TEND;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_TRD;
               end
            end
         end
         ST_TEND: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = status.hold_valid ? OUT_HOLD_LAST : OUT_EMPTY;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end
endmodule
`default_nettype wire

// ----- design/pps_datapath.sv -----
// Datapath for the particle pool core: configuration registers, LFSR, live
// bits, pool RAM, shared multiplier, alpha divider and result register.
// Depends on pps_pkg and pps_ram.
`default_nettype none
module pps_datapath import pps_pkg::*; #(
   parameter int POOL_SIZE = POOL_SIZE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pps_cmd_type              cmd,
   output pps_status_type                status,
   input  wire logic signed [WORD_W-1:0] in_spawn_x,
   input  wire logic signed [WORD_W-1:0] in_spawn_y,
   input  wire logic signed [WORD_W-1:0] in_spawn_z,
   input  wire logic [WORD_W-1:0]        in_elapsed_time,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [WORD_W-1:0]        csr_wr_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic                          out_kind,
   output logic [SLOT_W-1:0]             out_slot,
   output logic [WORD_W-1:0]             out_pos_x,
   output logic [WORD_W-1:0]             out_pos_y,
   output logic [WORD_W-1:0]             out_pos_z,
   output logic [ALPHA_W-1:0]            out_alpha,
   output logic                          out_alive,
   output logic [COUNT_W-1:0]            out_spawned,
   output logic                          out_last
);
   localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int QUO_W = 16;

   // Configuration and LFSR.
   logic [COUNT_W-1:0] spawn_count_ff;
   logic [WORD_W-1:0]  init_life_ff;
   logic [SCALE_W-1:0] vel_scale_ff;
   logic [SEED_W-1:0]  lfsr_ff, lfsr_next, seed_val;

   assign lfsr_next = {1'b0, lfsr_ff[SEED_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
   assign seed_val  = (csr_wr_data[SEED_W-1:0] == '0) ? SEED_W'(1)
                                                      : csr_wr_data[SEED_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         spawn_count_ff <= RESET_SPAWN_COUNT;
         init_life_ff   <= RESET_INIT_LIFE;
         vel_scale_ff   <= RESET_VEL_SCALE;
         lfsr_ff        <= RESET_SEED;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_SPAWN_COUNT: spawn_count_ff <= csr_wr_data[COUNT_W-1:0];
               REG_INIT_LIFE:   init_life_ff   <= csr_wr_data;
               REG_VEL_SCALE:   vel_scale_ff   <= csr_wr_data[SCALE_W-1:0];
               REG_SEED:        lfsr_ff        <= seed_val;
               default: ;
            endcase
         end
         if (cmd.lfsr_step) begin
            lfsr_ff <= lfsr_next;
         end
      end
   end

   // Latched input item.
   logic [WORD_W-1:0] sx_ff, sy_ff, sz_ff, dt_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sx_ff <= in_spawn_x;
         sy_ff <= in_spawn_y;
         sz_ff <= in_spawn_z;
         dt_ff <= in_elapsed_time;
      end
   end

   // Live bits and spawn count.
   logic [POOL_SIZE-1:0] alive_ff;
   logic [COUNT_W-1:0]   started_ff;
   logic [AW-1:0]        addr;

   assign addr = cmd.slot[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff   <= '0;
         started_ff <= '0;
      end else begin
         if (cmd.load_req) begin
            started_ff <= '0;
         end else if (cmd.spawn_write) begin
            started_ff <= started_ff + 1'b1;
         end
         if (cmd.spawn_write) begin
            alive_ff[addr] <= 1'b1;
         end else if (cmd.kill) begin
            alive_ff[addr] <= 1'b0;
         end
      end
   end

   // Pool storage.
   pps_entry_type rd_entry, wr_entry;
   logic [ENTRY_W-1:0] rd_data;
   assign rd_entry = rd_data;

   // Shared multiplier, one product per cycle.
   logic signed [16:0]   u_center;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   mul_p;
   logic [63:0]          prod_ff;
   logic [WORD_W-1:0]    prod_mid;

   assign u_center = $signed({1'b0, lfsr_next}) - 17'sd32768;
   assign prod_mid = prod_ff[47:16];

   always_comb begin
      case (cmd.mul_sel)
         MUL_CENTER: begin
            mul_a = {{16{u_center[16]}}, u_center};
            mul_b = $signed({2'b00, vel_scale_ff});
         end
         MUL_UP: begin
            mul_a = $signed({17'd0, lfsr_next});
            mul_b = $signed({2'b00, vel_scale_ff});
         end
         MUL_TX: begin
            mul_a = {rd_entry.vel_x[WORD_W-1], rd_entry.vel_x};
            mul_b = $signed({1'b0, dt_ff});
         end
         MUL_TY: begin
            mul_a = {rd_entry.vel_y[WORD_W-1], rd_entry.vel_y};
            mul_b = $signed({1'b0, dt_ff});
         end
         default: begin
            mul_a = {rd_entry.vel_z[WORD_W-1], rd_entry.vel_z};
            mul_b = $signed({1'b0, dt_ff});
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= mul_p[63:0];
   end

   // Velocities for a spawn, new state for a tick.
   logic [WORD_W-1:0] vx_ff, vy_ff, life_new_ff, px_new_ff, py_new_ff, pz_new_ff;
   always_ff @(posedge clock) begin
      if (cmd.vel_x_load) vx_ff <= prod_mid;
      if (cmd.vel_y_load) vy_ff <= prod_mid;
      if (cmd.life_load) life_new_ff <= rd_entry.life - dt_ff;
      if (cmd.pos_x_load) px_new_ff <= rd_entry.pos_x + prod_mid;
      if (cmd.pos_y_load) py_new_ff <= rd_entry.pos_y + prod_mid;
      if (cmd.tick_write) pz_new_ff <= rd_entry.pos_z + prod_mid;
   end

   always_comb begin
      if (cmd.spawn_write) begin
         wr_entry = '{life: init_life_ff, pos_x: sx_ff, pos_y: sy_ff, pos_z: sz_ff,
                      vel_x: vx_ff, vel_y: vy_ff, vel_z: prod_mid};
      end else begin
         wr_entry = '{life: life_new_ff, pos_x: px_new_ff, pos_y: py_new_ff,
                      pos_z: rd_entry.pos_z + prod_mid, vel_x: rd_entry.vel_x,
                      vel_y: rd_entry.vel_y, vel_z: rd_entry.vel_z};
      end
   end

   pps_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_SIZE)) u_pool_ram (
      .clock   (clock),
      .wr_en   (cmd.spawn_write | cmd.tick_write),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // Alpha divider: restoring, one quotient bit per cycle. Life at or above
   // the initial life, or a zero initial life, saturates to one.
   logic [WORD_W-1:0]  rem_ff;
   logic [WORD_W:0]    rem_shift;
   logic [4:0]         div_cnt_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic               rem_ge;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, init_life_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.tick_write) begin
         div_cnt_ff <= (init_life_ff == '0 || life_new_ff >= init_life_ff)
                       ? 5'd0 : 5'(QUO_W);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_write) begin
         rem_ff   <= life_new_ff;
         alpha_ff <= (init_life_ff == '0 || life_new_ff >= init_life_ff)
                     ? ALPHA_ONE : '0;
      end else if (div_cnt_ff != '0) begin
         rem_ff   <= rem_ge ? WORD_W'(rem_shift - {1'b0, init_life_ff})
                            : rem_shift[WORD_W-1:0];
         alpha_ff <= {alpha_ff[ALPHA_W-2:0], rem_ge};
      end
   end

   // Holding stage for the most recent survivor.
   logic                hold_valid_ff;
   logic [SLOT_W-1:0]   hold_slot_ff;
   logic [WORD_W-1:0]   hold_x_ff, hold_y_ff, hold_z_ff;
   logic [ALPHA_W-1:0]  hold_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (cmd.load_req) begin
         hold_valid_ff <= 1'b0;
      end else if (cmd.hold_load) begin
         hold_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold_load) begin
         hold_slot_ff  <= cmd.slot;
         hold_x_ff     <= px_new_ff;
         hold_y_ff     <= py_new_ff;
         hold_z_ff     <= pz_new_ff;
         hold_alpha_ff <= alpha_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid <= 1'b1;
      end else if (out_ready) begin
         out_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_sel)
            OUT_SPAWN: begin
               out_kind    <= OP_SPAWN;
               out_slot    <= '0;
               out_pos_x   <= '0;
               out_pos_y   <= '0;
               out_pos_z   <= '0;
               out_alpha   <= '0;
               out_alive   <= 1'b0;
               out_spawned <= started_ff;
               out_last    <= 1'b1;
            end
            OUT_HOLD_MID, OUT_HOLD_LAST: begin
               out_kind    <= OP_TICK;
               out_slot    <= hold_slot_ff;
               out_pos_x   <= hold_x_ff;
               out_pos_y   <= hold_y_ff;
               out_pos_z   <= hold_z_ff;
               out_alpha   <= hold_alpha_ff;
               out_alive   <= 1'b1;
               out_spawned <= '0;
               out_last    <= (cmd.out_sel == OUT_HOLD_LAST);
            end
            default: begin
               out_kind    <= OP_TICK;
               out_slot    <= '0;
               out_pos_x   <= '0;
               out_pos_y   <= '0;
               out_pos_z   <= '0;
               out_alpha   <= '0;
               out_alive   <= 1'b0;
               out_spawned <= '0;
               out_last    <= 1'b1;
            end
         endcase
      end
   end

   assign status.alive_bit  = alive_ff[addr];
   assign status.spawn_full = (started_ff >= spawn_count_ff);
   assign status.dead       = (rd_entry.life <= dt_ff);
   assign status.div_done   = (div_cnt_ff == '0);
   assign status.out_busy   = out_valid;
   assign status.hold_valid = hold_valid_ff;
endmodule
`default_nettype wire

// ----- design/particle_pool_spawn_and_tick_core.sv -----
// Top level of the particle pool core: spawn bursts and Euler time steps.
// Depends on pps_pkg, pps_if, pps_ctrl, pps_datapath and pps_ram.
//
//   Channel    Direction   Handshake          Beat
//   req_chan   in          valid / ready      one spawn or tick command
//   rsp_chan   out         valid / ready      one report or particle state
//   csr_*      in          write enable only  one register write
//
// A spawn passes over live slots; for each particle started it draws three
// LFSR velocity components through the shared multiplier and writes the slot,
// then loads the report. A tick frees expiring particles; each survivor is
// written back after three multiplier products, then the divider forms its alpha.
// Reset is synchronous; the pool comes out empty with no clearing pass.
// A stalled result register holds the sequencer until it is taken.
`default_nettype none
module particle_pool_spawn_and_tick_core import pps_pkg::*; #(
   parameter int POOL_SIZE = POOL_SIZE_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   pps_req_if.sink                   req_chan,
   pps_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wr_data
);
   pps_cmd_type    cmd;
   pps_status_type status;
   logic           ready;
   logic [WORD_W-1:0] pos_x, pos_y, pos_z;

   assign req_chan.ready = ready;

   pps_ctrl #(.POOL_SIZE(POOL_SIZE)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (ready),
      .cmd        (cmd),
      .status     (status)
   );

   pps_datapath #(.POOL_SIZE(POOL_SIZE)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_spawn_x      (req_chan.spawn_x),
      .in_spawn_y      (req_chan.spawn_y),
      .in_spawn_z      (req_chan.spawn_z),
      .in_elapsed_time (req_chan.elapsed_time),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .out_valid       (rsp_chan.valid),
      .out_ready       (rsp_chan.ready),
      .out_kind        (rsp_chan.kind),
      .out_slot        (rsp_chan.slot),
      .out_pos_x       (pos_x),
      .out_pos_y       (pos_y),
      .out_pos_z       (pos_z),
      .out_alpha       (rsp_chan.alpha),
      .out_alive       (rsp_chan.alive),
      .out_spawned     (rsp_chan.spawned),
      .out_last        (rsp_chan.last)
   );

   assign rsp_chan.pos_x = $signed(pos_x);
   assign rsp_chan.pos_y = $signed(pos_y);
   assign rsp_chan.pos_z = $signed(pos_z);
endmodule
`default_nettype wire

// ----- tb/particle_pool_spawn_and_tick_core_tb.sv -----
// Self-checking testbench for the particle pool core: spawn bursts and ticks
// are checked beat by beat against a behavioral pool model kept in the bench.
// Depends on pps_pkg, pps_if and the particle_pool_spawn_and_tick_core RTL.
`default_nettype none
module particle_pool_spawn_and_tick_core_tb;
   import pps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOTS = POOL_SIZE_DEF;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic              op;
      logic [WORD_W-1:0] x, y, z;
      logic [WORD_W-1:0] dt;
   } command_type;

   typedef struct {
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      logic [WORD_W-1:0]  px, py, pz;
      logic [ALPHA_W-1:0] alpha;
      logic               alive;
      logic [COUNT_W-1:0] spawned;
      logic               last;
   } report_type;

   logic clock = 0;
   logic reset = 1;
   logic                 csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wr_data = '0;

   pps_req_if req_bus ();
   pps_rsp_if rsp_bus ();

   particle_pool_spawn_and_tick_core dut (
      .clock(clock), .reset(reset), .req_chan(req_bus), .rsp_chan(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Pool model state and register copies.
   logic [COUNT_W-1:0] cfg_count;
   logic [WORD_W-1:0]  cfg_life;
   logic [SCALE_W-1:0] cfg_scale;
   logic [SEED_W-1:0]  lfsr;
   logic               live[NSLOTS];
   logic [WORD_W-1:0]  life_m[NSLOTS];
   logic [WORD_W-1:0]  pos_m[NSLOTS][3];
   logic [WORD_W-1:0]  vel_m[NSLOTS][3];

   command_type pending_cmds[$];
   report_type  expected_reports[$];
   command_type cur_cmd;
   int          failures = 0;
   longint      cycle_count = 0;

   task automatic add_cmd(command_type c);
      pending_cmds = {pending_cmds, c};
   endtask

   task automatic add_report(report_type r);
      expected_reports = {expected_reports, r};
   endtask

   function automatic logic [SEED_W-1:0] lfsr_next();
      logic out_bit;
      out_bit = lfsr[0];
      lfsr = lfsr >> 1;
      if (out_bit) lfsr = lfsr ^ LFSR_TAPS;
      return lfsr;
   endfunction

   function automatic logic [WORD_W-1:0] centered_vel(logic [SEED_W-1:0] u);
      longint p;
      p = (longint'(u) - 32768) * longint'(cfg_scale);
      return WORD_W'(p >>> 16);
   endfunction

   function automatic logic [WORD_W-1:0] step_pos(logic [WORD_W-1:0] pos,
                                                  logic [WORD_W-1:0] vel,
                                                  logic [WORD_W-1:0] dt);
      longint p;
      p = longint'($signed(vel)) * longint'({32'b0, dt});
      return pos + WORD_W'(p >>> 16);
   endfunction

   function automatic logic [ALPHA_W-1:0] life_fraction(logic [WORD_W-1:0] lf);
      logic [63:0] a;
      if (cfg_life == 0) return ALPHA_ONE;
      a = {lf, 16'b0} / {32'b0, cfg_life};
      return (a > 64'd65536) ? ALPHA_ONE : ALPHA_W'(a);
   endfunction

   // Works out the reports of one accepted command and updates the pool.
   task automatic predict_pool(command_type c);
      report_type r;
      int started;
      int n;
      logic [SEED_W-1:0] u;
      r = '{default: '0};
      started = 0;
      n = 0;
      if (c.op == OP_SPAWN) begin
         for (int i = 0; i < NSLOTS && started < cfg_count; i++) begin
            if (live[i]) continue;
            live[i] = 1;
            pos_m[i][0] = c.x;
            pos_m[i][1] = c.y;
            pos_m[i][2] = c.z;
            u = lfsr_next();
            vel_m[i][0] = centered_vel(u);
            u = lfsr_next();
            vel_m[i][1] = WORD_W'((longint'(u) * longint'(cfg_scale)) >> 16);
            u = lfsr_next();
            vel_m[i][2] = centered_vel(u);
            life_m[i] = cfg_life;
            started++;
         end
         r.spawned = COUNT_W'(started);
         r.last = 1;
         add_report(r);
      end else begin
         for (int i = 0; i < NSLOTS; i++) begin
            if (!live[i]) continue;
            if (life_m[i] <= c.dt) begin
               live[i] = 0;
               continue;
            end
            life_m[i] = life_m[i] - c.dt;
            for (int k = 0; k < 3; k++) begin
               pos_m[i][k] = step_pos(pos_m[i][k], vel_m[i][k], c.dt);
            end
            r.kind = 1;
            r.slot = SLOT_W'(i);
            r.px = pos_m[i][0];
            r.py = pos_m[i][1];
            r.pz = pos_m[i][2];
            r.alpha = life_fraction(life_m[i]);
            r.alive = 1;
            r.last = 0;
            add_report(r);
            n++;
         end
         if (n == 0) begin
            r = '{default: '0};
            r.kind = 1;
            r.last = 1;
            add_report(r);
         end else begin
            expected_reports[$].last = 1;
         end
      end
   endtask

   // Sender side: idles with probability 19 in a hundred, except in a stretch with no random idling.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_bus.valid <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_pool(cur_cmd);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_cmds.size() > 0 &&
                ((cycle_count > 30000 && cycle_count < 90000) ||
                 $urandom_range(99) >= 19)) begin
               cur_cmd = pending_cmds.pop_front();
               req_bus.valid <= 1;
               req_bus.opcode <= cur_cmd.op;
               req_bus.spawn_x <= cur_cmd.x;
               req_bus.spawn_y <= cur_cmd.y;
               req_bus.spawn_z <= cur_cmd.z;
               req_bus.elapsed_time <= cur_cmd.dt;
            end else begin
               req_bus.valid <= 0;
            end
         end
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input.
   int hold_cycles = 0;
   logic hold_off = 0;
   always @(posedge clock) begin
      if (cycle_count == 6000) begin
         hold_off <= 1;
         hold_cycles <= 0;
      end else if (hold_off) begin
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 4000) hold_off <= 0;
      end
   end

   // Receiver side: checks each beat against the oldest expected report.
   always @(posedge clock) begin
      report_type e;
      if (reset) begin
         rsp_bus.ready <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected beat kind=%0d slot=%0d", $time,
                        rsp_bus.kind, rsp_bus.slot);
               failures++;
            end else begin
               e = expected_reports.pop_front();
               if (rsp_bus.kind !== e.kind || rsp_bus.slot !== e.slot ||
                   rsp_bus.pos_x !== e.px || rsp_bus.pos_y !== e.py ||
                   rsp_bus.pos_z !== e.pz || rsp_bus.alpha !== e.alpha ||
                   rsp_bus.alive !== e.alive || rsp_bus.spawned !== e.spawned ||
                   rsp_bus.last !== e.last) begin
                  $display({"%0t: mismatch expected kind=%0d slot=%0d x=%h y=%h",
                            " z=%h a=%0d alive=%0d sp=%0d last=%0d"},
                           $time, e.kind, e.slot, e.px, e.py, e.pz, e.alpha,
                           e.alive, e.spawned, e.last);
                  $display({"%0t:          actual kind=%0d slot=%0d x=%h y=%h",
                            " z=%h a=%0d alive=%0d sp=%0d last=%0d"},
                           $time, rsp_bus.kind, rsp_bus.slot, rsp_bus.pos_x,
                           rsp_bus.pos_y, rsp_bus.pos_z, rsp_bus.alpha,
                           rsp_bus.alive, rsp_bus.spawned, rsp_bus.last);
                  failures++;
               end
            end
         end
         rsp_bus.ready <= !hold_off &&
                          ((cycle_count > 30000 && cycle_count < 90000) ||
                           $urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || expected_reports.size() > 0 || req_bus.valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      case (idx)
         REG_SPAWN_COUNT: cfg_count = val[COUNT_W-1:0];
         REG_INIT_LIFE:   cfg_life = val;
         REG_VEL_SCALE:   cfg_scale = val[SCALE_W-1:0];
         REG_SEED:        lfsr = (val[SEED_W-1:0] == 0) ? 16'd1 : val[SEED_W-1:0];
         default: ;
      endcase
   endtask

   function automatic command_type spawn_at(logic [WORD_W-1:0] x, y, z);
      command_type c;
      c = '{op: OP_SPAWN, x: x, y: y, z: z, dt: $urandom()};
      return c;
   endfunction

   function automatic command_type tick_by(logic [WORD_W-1:0] dt);
      command_type c;
      c = '{op: OP_TICK, x: $urandom(), y: $urandom(), z: $urandom(), dt: dt};
      return c;
   endfunction

   function automatic logic [WORD_W-1:0] random_dt();
      int sel;
      sel = $urandom_range(99);
      if (sel < 3) return 0;
      if (sel < 6) return $urandom();
      if (sel < 8) return 32'hFFFF_FFFF;
      return $urandom_range(0, (cfg_life >> 3) + 1);
   endfunction

   initial begin
      cfg_count = RESET_SPAWN_COUNT;
      cfg_life = RESET_INIT_LIFE;
      cfg_scale = RESET_VEL_SCALE;
      lfsr = RESET_SEED;
      foreach (live[i]) live[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 0;

      // Directed part under reset settings.
      add_cmd(tick_by(32'd100));
      add_cmd(spawn_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
      add_cmd(tick_by(32'd0));
      add_cmd(spawn_at(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
      add_cmd(spawn_at(32'h1234_5678, 32'h0, 32'h8000_0000));
      add_cmd(tick_by(32'd4096));
      wait_drained();
      write_reg(REG_SPAWN_COUNT, 64);
      write_reg(REG_VEL_SCALE, 32'h7FFF_FFFF);
      add_cmd(spawn_at(32'h0, 32'h0, 32'h0));
      add_cmd(tick_by(32'd30000));
      add_cmd(tick_by(32'hFFFF_FFFF));
      add_cmd(spawn_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      wait_drained();
      // Life above initial life: alpha saturates.
      write_reg(REG_INIT_LIFE, 32'd1000);
      write_reg(REG_SEED, 0);
      write_reg(4'd9, 32'hFFFF_FFFF);
      write_reg(REG_VEL_SCALE, 0);
      add_cmd(tick_by(32'd5));
      add_cmd(spawn_at($urandom(), $urandom(), $urandom()));
      add_cmd(tick_by(32'd1));
      add_cmd(tick_by(32'hFFFF_FFFF));
      wait_drained();
      // Zero initial life: spawned particles are freed on the next tick.
      write_reg(REG_INIT_LIFE, 0);
      write_reg(REG_SPAWN_COUNT, 0);
      add_cmd(spawn_at(32'h1, 32'h2, 32'h3));
      wait_drained();
      write_reg(REG_SPAWN_COUNT, 5);
      add_cmd(spawn_at(32'h1, 32'h2, 32'h3));
      add_cmd(tick_by(32'd0));
      add_cmd(tick_by(32'd0));
      wait_drained();

      // Random phases, each with its own register setting.
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_SPAWN_COUNT, 64);
               write_reg(REG_INIT_LIFE, 32'hFFFF_FFFF);
               write_reg(REG_VEL_SCALE, 32'h7FFF_FFFF);
               write_reg(REG_SEED, 32'h0000_FFFF);
            end
            1: begin
               write_reg(REG_SPAWN_COUNT, 1);
               write_reg(REG_INIT_LIFE, 1);
               write_reg(REG_VEL_SCALE, 0);
               write_reg(REG_SEED, 1);
            end
            default: begin
               write_reg(REG_SPAWN_COUNT, $urandom_range(0, 20));
               write_reg(REG_INIT_LIFE, ($urandom_range(3) == 0) ? $urandom()
                                        : $urandom_range(1, 32'h0008_0000));
               write_reg(REG_VEL_SCALE, $urandom() >> 1);
               write_reg(REG_SEED, $urandom_range(1, 65535));
            end
         endcase
         for (int k = 0; k < 52; k++) begin
            if ($urandom_range(99) < 40)
               add_cmd(spawn_at($urandom(), $urandom(), $urandom()));
            else
               add_cmd(tick_by(random_dt()));
         end
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (failures == 0 && expected_reports.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
design/pps_pkg.sv
design/pps_if.sv
design/pps_ram.sv
design/pps_ctrl.sv
design/pps_datapath.sv
design/particle_pool_spawn_and_tick_core.sv
tb/particle_pool_spawn_and_tick_core_tb.sv
